FILE: design/feal_pkg.sv
// ----------------------------------------------------------------------------
// feal_pkg
// Shared types, constants and byte functions of the FEAL-N block cipher.
// ----------------------------------------------------------------------------
package feal_pkg;

    localparam int MAX_ROUNDS_DEF   = 32;
    localparam int SUBKEY_DEPTH_DEF = 40;

    localparam int KEY_W     = 64;
    localparam int BLOCK_W   = 64;
    localparam int WORD_W    = 32;
    localparam int SUBKEY_W  = 16;
    localparam int HALF_W    = 5;
    localparam int CNT_W     = HALF_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF = 2'd1;

    localparam logic [HALF_W-1:0] HALF_RESET = 5'd8;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KS_LOAD,
        ST_KS_HI,
        ST_KS_LO,
        ST_ROUND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic ks_load;
        logic ks_wr;
        logic ks_lo;
        logic blk_load;
        logic rd_en;
        logic round_en;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic logic [7:0] byte_mix(input logic [7:0] x, input logic [7:0] y,
                                            input logic d);
        logic [7:0] s;
        s = x + y + {7'd0, d};
        return {s[5:0], s[7:6]};
    endfunction

    function automatic logic [WORD_W-1:0] fk_func(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [7:0] p, q, u0, u1, u2, u3;
        p  = a[31:24] ^ a[23:16];
        q  = a[15:8] ^ a[7:0];
        u1 = byte_mix(p, q ^ b[31:24], 1'b1);
        u2 = byte_mix(q, u1 ^ b[23:16], 1'b0);
        u0 = byte_mix(a[31:24], u1 ^ b[15:8], 1'b0);
        u3 = byte_mix(a[7:0], u2 ^ b[7:0], 1'b1);
        return {u0, u1, u2, u3};
    endfunction

    function automatic logic [WORD_W-1:0] round_func(input logic [WORD_W-1:0] a,
                                                     input logic [SUBKEY_W-1:0] k);
        logic [7:0] p, q, f0, f1, f2, f3;
        p  = a[31:24] ^ a[23:16] ^ k[15:8];
        q  = a[15:8] ^ a[7:0] ^ k[7:0];
        f1 = byte_mix(p, q, 1'b1);
        f2 = byte_mix(q, f1, 1'b0);
        f0 = byte_mix(a[31:24], f1, 1'b0);
        f3 = byte_mix(a[7:0], f2, 1'b1);
        return {f0, f1, f2, f3};
    endfunction

endpackage

FILE: design/feal_ram.sv
// ----------------------------------------------------------------------------
// feal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module feal_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 40,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/feal_dp.sv
// ----------------------------------------------------------------------------
// feal_dp
// Datapath: config registers, fK key schedule words, subkey RAM, Feistel
// round register pair, whitening keys and output register.
// ----------------------------------------------------------------------------
module feal_dp import feal_pkg::*; #(
    parameter int SUBKEY_DEPTH = SUBKEY_DEPTH_DEF,
    parameter int ADDR_W       = $clog2(SUBKEY_DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_wdata,
    output logic [HALF_W-1:0]    cfg_half,
    input  ctrl_cmd_t            cmd,
    input  logic [ADDR_W-1:0]    ks_addr,
    input  logic [ADDR_W-1:0]    rd_addr,
    output dp_status_t           status,
    input  logic                 in_cmd,
    input  logic [BLOCK_W-1:0]   in_block,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BLOCK_W-1:0]   out_block
);

    logic [KEY_W-1:0]    key_reg;
    logic [HALF_W-1:0]   half_reg;
    logic [WORD_W-1:0]   ua_reg, ub_reg, uc_reg;
    logic [WORD_W-1:0]   wk_reg [4];
    logic [WORD_W-1:0]   x_reg, y_reg;
    logic                dir_reg;
    logic                out_valid_reg;
    logic [BLOCK_W-1:0]  out_block_reg;

    logic [WORD_W-1:0]   fk_word;
    logic [SUBKEY_W-1:0] ram_wdata;
    logic [SUBKEY_W-1:0] ram_rdata;
    logic [WORD_W-1:0]   in_l, in_r, init_c, init_d, init_y;
    logic [WORD_W-1:0]   fin_a, fin_b;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            half_reg <= HALF_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_KEY)
            begin
                key_reg <= cfg_wdata;
            end
            else if (cfg_index == CFG_HALF)
            begin
                half_reg <= cfg_wdata[HALF_W-1:0];
            end
        end
    end

    assign cfg_half = half_reg;

    // key schedule
    assign fk_word   = fk_func(ub_reg, uc_reg ^ ua_reg);
    assign ram_wdata = cmd.ks_lo ? fk_word[15:0] : fk_word[31:16];

    always_ff @(posedge clk)
    begin
        if (cmd.ks_load)
        begin
            ua_reg <= '0;
            ub_reg <= key_reg[63:32];
            uc_reg <= key_reg[31:0];
        end
        else if (cmd.ks_wr && cmd.ks_lo)
        begin
            ua_reg    <= ub_reg;
            ub_reg    <= uc_reg;
            uc_reg    <= fk_word;
            wk_reg[0] <= wk_reg[1];
            wk_reg[1] <= wk_reg[2];
            wk_reg[2] <= wk_reg[3];
            wk_reg[3] <= fk_word;
        end
    end

    feal_ram #(
        .WIDTH (SUBKEY_W),
        .DEPTH (SUBKEY_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_subkey_ram (
        .clk  (clk),
        .we   (cmd.ks_wr),
        .waddr(ks_addr),
        .wdata(ram_wdata),
        .re   (cmd.rd_en),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    // block path; x feeds f, y is the other half
    assign in_l   = in_block[63:32];
    assign in_r   = in_block[31:0];
    assign init_c = (in_cmd == CMD_DECRYPT) ? wk_reg[2] : wk_reg[0];
    assign init_d = (in_cmd == CMD_DECRYPT) ? wk_reg[3] : wk_reg[1];
    assign init_y = in_l ^ init_c;
    assign fin_a  = (dir_reg == CMD_DECRYPT) ? wk_reg[0] : wk_reg[2];
    assign fin_b  = (dir_reg == CMD_DECRYPT) ? wk_reg[1] : wk_reg[3];

    always_ff @(posedge clk)
    begin
        if (cmd.blk_load)
        begin
            y_reg   <= init_y;
            x_reg   <= in_r ^ init_d ^ init_y;
            dir_reg <= in_cmd;
        end
        else if (cmd.round_en)
        begin
            x_reg <= y_reg ^ round_func(x_reg, ram_rdata);
            y_reg <= x_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_block_reg <= {x_reg ^ fin_a, x_reg ^ y_reg ^ fin_b};
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_block       = out_block_reg;

endmodule

FILE: design/feal_ctrl.sv
// ----------------------------------------------------------------------------
// feal_ctrl
// Controller: key schedule sequencing, round counting and subkey addressing.
// ----------------------------------------------------------------------------
module feal_ctrl import feal_pkg::*; #(
    parameter int MAX_ROUNDS   = MAX_ROUNDS_DEF,
    parameter int SUBKEY_DEPTH = SUBKEY_DEPTH_DEF,
    parameter int ADDR_W       = $clog2(SUBKEY_DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_half,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_cmd,
    input  dp_status_t           status,
    output ctrl_cmd_t            cmd,
    output logic [ADDR_W-1:0]    ks_addr,
    output logic [ADDR_W-1:0]    rd_addr
);

    localparam int CAP_A    = MAX_ROUNDS / 2;
    localparam int CAP_B    = (SUBKEY_DEPTH - 8) / 2;
    localparam int HALF_CAP = (CAP_A < CAP_B) ? CAP_A : CAP_B;

    state_t            state_reg, state_next;
    logic              ready_reg, ready_next;
    logic [CNT_W-1:0]  iter_reg, iter_next;
    logic [ADDR_W-1:0] ks_addr_reg, ks_addr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              dir_reg, dir_next;

    logic [HALF_W-1:0] half_eff;
    logic [CNT_W-1:0]  n_rounds;
    logic              cfg_change;
    logic              accept;
    logic              ks_last;
    logic              round_last;

    always_comb
    begin
        if (cfg_half == '0)
        begin
            half_eff = HALF_W'(1);
        end
        else if (cfg_half > HALF_W'(HALF_CAP))
        begin
            half_eff = HALF_W'(HALF_CAP);
        end
        else
        begin
            half_eff = cfg_half;
        end
    end

    assign n_rounds   = {half_eff, 1'b0};
    assign cfg_change = cfg_we && ((cfg_index == CFG_KEY) || (cfg_index == CFG_HALF));
    assign accept     = (state_reg == ST_IDLE) && ready_reg && in_valid;
    assign ks_last    = iter_reg == (CNT_W'(half_eff) + CNT_W'(4));
    assign round_last = cnt_reg == (n_rounds - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ready_reg   <= 1'b0;
            iter_reg    <= '0;
            ks_addr_reg <= '0;
            cnt_reg     <= '0;
            dir_reg     <= CMD_ENCRYPT;
        end
        else
        begin
            state_reg   <= state_next;
            ready_reg   <= ready_next;
            iter_reg    <= iter_next;
            ks_addr_reg <= ks_addr_next;
            cnt_reg     <= cnt_next;
            dir_reg     <= dir_next;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        ready_next   = ready_reg;
        iter_next    = iter_reg;
        ks_addr_next = ks_addr_reg;
        cnt_next     = cnt_reg;
        dir_next     = dir_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!ready_reg)
                begin
                    state_next = ST_KS_LOAD;
                end
                else if (in_valid)
                begin
                    state_next = ST_ROUND;
                    cnt_next   = '0;
                    dir_next   = in_cmd;
                end
            end
            ST_KS_LOAD:
            begin
                state_next   = ST_KS_HI;
                iter_next    = CNT_W'(1);
                ks_addr_next = '0;
            end
            ST_KS_HI:
            begin
                state_next   = ST_KS_LO;
                ks_addr_next = ks_addr_reg + ADDR_W'(1);
            end
            ST_KS_LO:
            begin
                ks_addr_next = ks_addr_reg + ADDR_W'(1);
                iter_next    = iter_reg + CNT_W'(1);
                if (ks_last)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
                else
                begin
                    state_next = ST_KS_HI;
                end
            end
            ST_ROUND:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (round_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_change)
        begin
            state_next = ST_KS_LOAD;
            ready_next = 1'b0;
        end
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        rd_addr  = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = ready_reg;
                cmd.blk_load = accept;
                cmd.rd_en    = accept;
                rd_addr      = (in_cmd == CMD_DECRYPT) ?
                               ADDR_W'(n_rounds - CNT_W'(1)) : '0;
            end
            ST_KS_LOAD:
            begin
                cmd.ks_load = 1'b1;
            end
            ST_KS_HI:
            begin
                cmd.ks_wr = 1'b1;
            end
            ST_KS_LO:
            begin
                cmd.ks_wr = 1'b1;
                cmd.ks_lo = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                cmd.rd_en    = !round_last;
                rd_addr      = (dir_reg == CMD_DECRYPT) ?
                               ADDR_W'(n_rounds - CNT_W'(2) - cnt_reg) :
                               ADDR_W'(cnt_reg + CNT_W'(1));
            end
            ST_FINISH:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign ks_addr = ks_addr_reg;

endmodule

FILE: design/feal_block_cipher_top.sv
// ----------------------------------------------------------------------------
// feal_block_cipher_top
// FEAL-N block cipher with programmable key and round count.
//
// Channel   Dir  Signals                         Content
// s_axis    in   tvalid/tready/tdata/tuser       tdata: data_block, tuser: command
// m_axis    out  tvalid/tready/tdata             tdata: result_block
// cfg       in   cfg_we/cfg_index/cfg_wdata      0: cipher_key, 1: half_rounds
//
// A request runs as one load, one Feistel round per cycle fed by the subkey
// RAM, and a final step that whitens into the output reg.
// After reset and after any key or round-count write, the key schedule runs
// before a request is taken.
// A full output register stalls only the final step; a new request is taken
// while the previous result waits.
// ----------------------------------------------------------------------------
module feal_block_cipher_top import feal_pkg::*; #(
    parameter int MAX_ROUNDS   = MAX_ROUNDS_DEF,
    parameter int SUBKEY_DEPTH = SUBKEY_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BLOCK_W-1:0]   s_axis_tdata,   // [63:0] data_block
    input  logic                 s_axis_tuser,   // [0] command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [BLOCK_W-1:0]   m_axis_tdata,   // [63:0] result_block
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_wdata
);

    localparam int ADDR_W = $clog2(SUBKEY_DEPTH);

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [HALF_W-1:0] cfg_half;
    logic [ADDR_W-1:0] ks_addr;
    logic [ADDR_W-1:0] rd_addr;

    feal_ctrl #(
        .MAX_ROUNDS  (MAX_ROUNDS),
        .SUBKEY_DEPTH(SUBKEY_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_half (cfg_half),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser),
        .status   (status),
        .cmd      (cmd),
        .ks_addr  (ks_addr),
        .rd_addr  (rd_addr)
    );

    feal_dp #(
        .SUBKEY_DEPTH(SUBKEY_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cfg_half (cfg_half),
        .cmd      (cmd),
        .ks_addr  (ks_addr),
        .rd_addr  (rd_addr),
        .status   (status),
        .in_cmd   (s_axis_tuser),
        .in_block (s_axis_tdata),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_block(m_axis_tdata)
    );

endmodule

FILE: design/feal_checker.sv
// ----------------------------------------------------------------------------
// feal_checker
// Port-level checks on the FEAL-N top level, bound to every instance.
// ----------------------------------------------------------------------------
module feal_checker import feal_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [BLOCK_W-1:0]   m_axis_tdata,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one in flight");

    a_rekey_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && ((cfg_index == CFG_KEY) || (cfg_index == CFG_HALF)) |=> !s_axis_tready)
        else $error("request window open before key schedule rerun");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a request in progress");

endmodule

bind feal_block_cipher_top feal_checker u_feal_checker (.*);

FILE: tb/sv/feal_block_cipher_top_test.sv
// ----------------------------------------------------------------------------
// feal_block_cipher_top_test
// Self-checking regression for the FEAL-N cipher top. A scoreboard class keeps
// its own key schedule and FEAL data path, predicts every output block from
// the accepted requests and compares results in order. Stimulus covers the
// reset key, extreme blocks, a spread of round counts including out-of-range
// values, writes to unused register slots, encrypt/decrypt round trips, random
// back-pressure on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module feal_block_cipher_top_test import feal_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_CAP = (MAX_ROUNDS_DEF / 2 < (SUBKEY_DEPTH_DEF - 8) / 2) ?
                              MAX_ROUNDS_DEF / 2 : (SUBKEY_DEPTH_DEF - 8) / 2;
    localparam int SETTLE_CYCLES   = 2 * MAX_ROUNDS_DEF + 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    class feal_cipher_scoreboard;
        logic [KEY_W-1:0]    key;
        logic [HALF_W-1:0]   half_setting;
        logic [SUBKEY_W-1:0] subkey [SUBKEY_DEPTH_DEF];
        bit                  subkeys_valid;
        logic [BLOCK_W-1:0]  expected_blocks [$];
        logic [BLOCK_W-1:0]  last_predicted;
        int                  mismatches;
        int                  matched;
        int                  encrypts;
        int                  decrypts;

        function new();
            key           = '0;
            half_setting  = HALF_RESET;
            subkeys_valid = 1'b0;
            last_predicted = '0;
            mismatches    = 0;
            matched       = 0;
            encrypts      = 0;
            decrypts      = 0;
            foreach (subkey[i])
                subkey[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [KEY_W-1:0] data);
            case (index)
                CFG_KEY:
                begin
                    key           = data;
                    subkeys_valid = 1'b0;
                end
                CFG_HALF:
                begin
                    half_setting  = data[HALF_W-1:0];
                    subkeys_valid = 1'b0;
                end
                default: ;
            endcase
        endfunction

        // round count N after clamping the programmed half count
        function int rounds();
            int h;
            h = int'(half_setting);
            if (h < 1)
                h = 1;
            if (h > HALF_CAP)
                h = HALF_CAP;
            return 2 * h;
        endfunction

        function logic [7:0] sd(logic [7:0] a, logic [7:0] b, logic carry);
            logic [7:0] sum;
            sum = a + b + {7'd0, carry};
            return (sum << 2) | (sum >> 6);
        endfunction

        function logic [31:0] fk(logic [31:0] a, logic [31:0] b);
            logic [7:0] t0, t1, t2, t3;
            t1 = sd(a[31:24] ^ a[23:16], a[15:8] ^ a[7:0] ^ b[31:24], 1'b1);
            t2 = sd(a[15:8] ^ a[7:0], t1 ^ b[23:16], 1'b0);
            t0 = sd(a[31:24], t1 ^ b[15:8], 1'b0);
            t3 = sd(a[7:0], t2 ^ b[7:0], 1'b1);
            return {t0, t1, t2, t3};
        endfunction

        function logic [31:0] f_round(logic [31:0] a, logic [15:0] k);
            logic [31:0] x;
            logic [7:0]  t0, t1, t2, t3;
            x  = a ^ {8'h00, k, 8'h00};
            t1 = sd(x[31:24] ^ x[23:16], x[15:8] ^ x[7:0], 1'b1);
            t2 = sd(x[15:8] ^ x[7:0], t1, 1'b0);
            t0 = sd(x[31:24], t1, 1'b0);
            t3 = sd(x[7:0], t2, 1'b1);
            return {t0, t1, t2, t3};
        endfunction

        function void expand();
            logic [31:0] u [0:HALF_CAP+7];
            int h;
            h = rounds() / 2;
            foreach (u[i])
                u[i] = '0;
            u[1] = key[63:32];
            u[2] = key[31:0];
            for (int i = 1; i <= h + 4; i++)
            begin
                u[i+2]       = fk(u[i], u[i+1] ^ u[i-1]);
                subkey[2*i-2] = u[i+2][31:16];
                subkey[2*i-1] = u[i+2][15:0];
            end
            subkeys_valid = 1'b1;
        endfunction

        function logic [31:0] pair(int idx);
            return {subkey[idx], subkey[idx+1]};
        endfunction

        function logic [BLOCK_W-1:0] encrypt_block(logic [BLOCK_W-1:0] blk);
            logic [31:0] l, r, t;
            int n;
            n = rounds();
            l = blk[63:32] ^ pair(n);
            r = blk[31:0] ^ pair(n + 2) ^ l;
            for (int i = 0; i < n; i++)
            begin
                t = l ^ f_round(r, subkey[i]);
                l = r;
                r = t;
            end
            l = l ^ r ^ pair(n + 6);
            r = r ^ pair(n + 4);
            return {r, l};
        endfunction

        function logic [BLOCK_W-1:0] decrypt_block(logic [BLOCK_W-1:0] blk);
            logic [31:0] l, r, t;
            int n;
            n = rounds();
            r = blk[63:32] ^ pair(n + 4);
            l = blk[31:0] ^ pair(n + 6) ^ r;
            for (int i = n; i >= 1; i--)
            begin
                t = r ^ f_round(l, subkey[i-1]);
                r = l;
                l = t;
            end
            r = r ^ l ^ pair(n + 2);
            l = l ^ pair(n);
            return {l, r};
        endfunction

        function void note_request(logic cmd, logic [BLOCK_W-1:0] blk);
            if (!subkeys_valid)
                expand();
            if (cmd == CMD_ENCRYPT)
            begin
                last_predicted = encrypt_block(blk);
                encrypts++;
            end
            else
            begin
                last_predicted = decrypt_block(blk);
                decrypts++;
            end
            expected_blocks.push_back(last_predicted);
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [BLOCK_W-1:0] got);
            logic [BLOCK_W-1:0] want;
            if (expected_blocks.size() == 0)
                report($sformatf("result_block %h with no request outstanding", got));
            else
            begin
                want = expected_blocks.pop_front();
                if (got !== want)
                    report($sformatf("result_block got %h want %h", got, want));
                else
                    matched++;
            end
        endtask

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [BLOCK_W-1:0]   s_axis_tdata;   // [63:0] data_block
    logic                 s_axis_tuser;   // [0] command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [BLOCK_W-1:0]   m_axis_tdata;   // [63:0] result_block
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEY_W-1:0]     cfg_wdata;

    feal_cipher_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int idle_cycles    = 0;
    int settings_used  = 0;
    int holds_done     = 0;
    logic last_cmd     = CMD_ENCRYPT;

    feal_block_cipher_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    // output side: random stalls, plus a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no progress for %0d cycles, %0d results outstanding",
                         $realtime, idle_cycles, sb.pending());
                $display("feal_block_cipher_top regression: fail");
                $finish;
            end
        end
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_block(input logic cmd, input logic [BLOCK_W-1:0] blk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(cmd, blk);
        last_cmd = cmd;
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] half_word,
                                 input bit write_main, input bit with_spare);
        logic [CFG_IDX_W-1:0] idx_list [$];
        logic [KEY_W-1:0]     data_list [$];
        drain();
        if (write_main)
        begin
            idx_list.push_back(CFG_KEY);
            data_list.push_back(key);
        end
        if (with_spare)
        begin
            idx_list.push_back(CFG_SPARE_A);
            data_list.push_back({$urandom, $urandom});
            idx_list.push_back(CFG_SPARE_B);
            data_list.push_back({$urandom, $urandom});
        end
        if (write_main)
        begin
            idx_list.push_back(CFG_HALF);
            data_list.push_back(half_word);
        end
        foreach (idx_list[i])
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_wdata <= data_list[i];
            @(posedge clk);
            sb.write_reg(idx_list[i], data_list[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_batch(input int count, input bit pause_midway);
        logic                cmd;
        logic [BLOCK_W-1:0]  blk;
        int                  pick;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
            begin
                s_axis_tvalid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            pick = $urandom_range(99);
            if (pick < 25 && sb.encrypts + sb.decrypts > 0)
            begin
                // feed the last output back the other way
                cmd = ~last_cmd;
                blk = sb.last_predicted;
            end
            else if (pick < 32)
            begin
                cmd = 1'($urandom_range(1));
                blk = $urandom_range(1) ? '1 : '0;
                blk[$urandom_range(BLOCK_W-1)] ^= 1'b1;
            end
            else
            begin
                cmd = 1'($urandom_range(1));
                blk = {$urandom, $urandom};
            end
            send_block(cmd, blk);
        end
    endtask

    initial
    begin
        logic [BLOCK_W-1:0] corner [10];
        logic [KEY_W-1:0]   half_word;

        corner = '{64'h0, '1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                   64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                   64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
                   64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ENCRYPT;
        cfg_we        = 1'b0;
        cfg_index     = CFG_KEY;
        cfg_wdata     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset key and FEAL-16, corner blocks both ways
        foreach (corner[i])
        begin
            send_block(CMD_ENCRYPT, corner[i]);
            send_block(CMD_DECRYPT, corner[i]);
        end

        apply_setting('1, 64'd16, 1'b1, 1'b0);
        run_batch(130, 1'b0);

        send_idle_pct = 72;
        apply_setting({$urandom, $urandom}, 64'd1, 1'b1, 1'b1);
        run_batch(130, 1'b1);

        send_idle_pct  = 0;
        recv_stall_pct = 72;
        apply_setting({$urandom, $urandom}, 64'd0, 1'b1, 1'b0);
        run_batch(130, 1'b0);

        send_idle_pct  = 12;
        recv_stall_pct = 12;
        half_word = {$urandom, $urandom};
        half_word[HALF_W-1:0] = 5'd31;
        apply_setting({$urandom, $urandom}, half_word, 1'b1, 1'b0);
        run_batch(130, 1'b0);

        // output held off while input keeps coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_setting(64'h8000_0000_0000_0000, 64'd17, 1'b1, 1'b1);
        hold_req = 1'b1;
        run_batch(130, 1'b0);

        // unused slots only: schedule must survive
        send_idle_pct = 72;
        apply_setting('0, '0, 1'b0, 1'b1);
        run_batch(100, 1'b0);

        for (int p = 0; p < 7; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            half_word = {$urandom, $urandom};
            half_word[HALF_W-1:0] = HALF_W'($urandom_range(31));
            apply_setting({$urandom, $urandom}, half_word, 1'b1, $urandom_range(1));
            run_batch(125, p == 5);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d blocks checked (%0d encrypt, %0d decrypt) over %0d settings,",
                 sb.matched, sb.encrypts, sb.decrypts, settings_used);
        $display("summary: clamped and random round counts, %0d output hold-offs, %0d mismatches",
                 holds_done, sb.mismatches);
        if (sb.mismatches == 0)
            $display("feal_block_cipher_top regression: pass");
        else
            $display("feal_block_cipher_top regression: fail");
        $finish;
    end

endmodule
